// ===== design/bf4s_pkg.sv =====
// shared types, constants and saturation helpers for the 4d box fold and scale block
package bf4s_pkg;

   localparam int NUM_STAGES    = 5;
   localparam int STAGE_REGS    = 5;
   localparam int ACTIVE_STAGES = (NUM_STAGES < STAGE_REGS) ? NUM_STAGES : STAGE_REGS;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOLD_LIMIT    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLD_VALUE    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_FACTORS = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_ONE     = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_TWO     = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_THREE   = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_FOUR    = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_FIVE    = CSR_INDEX_W'(7);

   localparam logic [30:0] FOLD_LIMIT_RESET    = 31'd1048576;
   localparam logic [31:0] FOLD_VALUE_RESET    = 32'd2097152;
   localparam logic [63:0] COLOR_FACTORS_RESET = 64'd0;
   localparam logic [55:0] STAGE_RESET         = 56'd65536;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic [47:0]        DERIV_MAX = 48'hFFFF_FFFF_FFFF;

   typedef logic signed [31:0] coord_type;
   typedef logic [55:0]        stage_type;

   typedef struct packed {
      coord_type [3:0] c;
      logic [47:0]     deriv;
      logic [31:0]     colour;
      logic [15:0]     iteration;
   } item_type;

   typedef struct packed {
      logic [30:0] fold_limit;
      logic [31:0] fold_value;
      logic [63:0] color_factors;
   } cfg_type;

   function automatic coord_type sat_s34(input logic signed [33:0] v);
      if (v[33:31] != {3{v[33]}}) begin
         return v[33] ? COORD_MIN : COORD_MAX;
      end
      return v[31:0];
   endfunction

   function automatic coord_type sat_s40(input logic signed [39:0] v);
      if (v[39:31] != {9{v[39]}}) begin
         return v[39] ? COORD_MIN : COORD_MAX;
      end
      return v[31:0];
   endfunction

endpackage

// ===== design/box_fold_4d_scale.sv =====
// top level: config registers, box fold and the chain of scale stages
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     point, derivative, colour, iteration
//   rsp      out        rsp_valid / rsp_ready     point, derivative, colour
//   csr      in         csr_we                    csr_index, csr_wdata
//
// one request per cycle while rsp is not stalled
// the fold stage and each scale stage (multiply, then round and saturate) set the depth
// every stage has its own valid bit and takes data when empty or when its successor moves,
// so bubbles close up and a stalled rsp holds its request without loss
// synchronous reset clears the valid bits and loads the config register reset values
module box_fold_4d_scale import bf4s_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_coord_x,
   input  logic signed [31:0]     req_coord_y,
   input  logic signed [31:0]     req_coord_z,
   input  logic signed [31:0]     req_coord_w,
   input  logic [47:0]            req_deriv_in,
   input  logic signed [31:0]     req_colour_in,
   input  logic [15:0]            req_iteration,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_out_x,
   output logic signed [31:0]     rsp_out_y,
   output logic signed [31:0]     rsp_out_z,
   output logic signed [31:0]     rsp_out_w,
   output logic [47:0]            rsp_deriv_out,
   output logic signed [31:0]     rsp_colour_out,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [30:0] fold_limit_ff;
   logic [31:0] fold_value_ff;
   logic [63:0] color_factors_ff;
   stage_type   stage_ff [STAGE_REGS];
   cfg_type     cfg;

   item_type req_item;
   item_type link_item  [ACTIVE_STAGES+1];
   logic     link_valid [ACTIVE_STAGES+1];
   logic     link_ready [ACTIVE_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_limit_ff    <= FOLD_LIMIT_RESET;
         fold_value_ff    <= FOLD_VALUE_RESET;
         color_factors_ff <= COLOR_FACTORS_RESET;
         for (int k = 0; k < STAGE_REGS; k++) begin
            stage_ff[k] <= STAGE_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FOLD_LIMIT:    fold_limit_ff    <= csr_wdata[30:0];
            CSR_FOLD_VALUE:    fold_value_ff    <= csr_wdata[31:0];
            CSR_COLOR_FACTORS: color_factors_ff <= csr_wdata[63:0];
            CSR_STAGE_ONE:     stage_ff[0]      <= csr_wdata[55:0];
            CSR_STAGE_TWO:     stage_ff[1]      <= csr_wdata[55:0];
            CSR_STAGE_THREE:   stage_ff[2]      <= csr_wdata[55:0];
            CSR_STAGE_FOUR:    stage_ff[3]      <= csr_wdata[55:0];
            CSR_STAGE_FIVE:    stage_ff[4]      <= csr_wdata[55:0];
            default: ;
         endcase
      end
   end

   assign cfg.fold_limit    = fold_limit_ff;
   assign cfg.fold_value    = fold_value_ff;
   assign cfg.color_factors = color_factors_ff;

   assign req_item.c[0]     = req_coord_x;
   assign req_item.c[1]     = req_coord_y;
   assign req_item.c[2]     = req_coord_z;
   assign req_item.c[3]     = req_coord_w;
   assign req_item.deriv    = req_deriv_in;
   assign req_item.colour   = req_colour_in;
   assign req_item.iteration = req_iteration;

   bf4s_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_item  (link_item[0])
   );

   for (genvar k = 0; k < ACTIVE_STAGES; k++) begin : g_stage
      bf4s_scale u_scale (
         .clock     (clock),
         .reset     (reset),
         .stage_cfg (stage_ff[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_item   (link_item[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_item  (link_item[k+1])
      );
   end

   assign link_ready[ACTIVE_STAGES] = rsp_ready;
   assign rsp_valid      = link_valid[ACTIVE_STAGES];
   assign rsp_out_x      = link_item[ACTIVE_STAGES].c[0];
   assign rsp_out_y      = link_item[ACTIVE_STAGES].c[1];
   assign rsp_out_z      = link_item[ACTIVE_STAGES].c[2];
   assign rsp_out_w      = link_item[ACTIVE_STAGES].c[3];
   assign rsp_deriv_out  = link_item[ACTIVE_STAGES].deriv;
   assign rsp_colour_out = link_item[ACTIVE_STAGES].colour;

   // with the output register empty the whole chain can move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output register is empty");

endmodule

// ===== design/bf4s_fold.sv =====
// box fold of the four coordinates, then the colour update, two register stages
module bf4s_fold import bf4s_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   logic       f_valid_ff;
   logic       f_valid_in;
   item_type   f_item_ff;
   item_type   f_item_in;
   logic [3:0] f_chg_ff;
   logic [3:0] f_chg_in;
   logic       f_en;

   logic       k_valid_ff;
   logic       k_valid_in;
   item_type   k_item_ff;
   item_type   k_item_in;
   logic       k_en;

   assign k_en       = !k_valid_ff || out_ready;
   assign f_en       = !f_valid_ff || k_en;
   assign in_ready   = f_en;
   assign f_valid_in = in_valid;
   assign k_valid_in = f_valid_ff;

   // fold against the symmetric limit
   always_comb begin
      logic signed [33:0] c34;
      logic signed [33:0] lim34;
      logic signed [33:0] fv34;
      f_item_in = in_item;
      f_chg_in  = '0;
      lim34     = {3'b000, cfg.fold_limit};
      fv34      = {{2{cfg.fold_value[31]}}, cfg.fold_value};
      for (int a = 0; a < 4; a++) begin
         c34 = {{2{in_item.c[a][31]}}, in_item.c[a]};
         if (c34 > lim34) begin
            f_item_in.c[a] = sat_s34(fv34 - c34);
         end else if (c34 < -lim34) begin
            f_item_in.c[a] = sat_s34(-fv34 - c34);
         end
         f_chg_in[a] = (f_item_in.c[a] != in_item.c[a]);
      end
   end

   // colour gains each changed axis's factor in order x, y, z, w
   always_comb begin
      logic signed [33:0] col34;
      logic signed [33:0] fac34;
      logic [15:0]        fac;
      coord_type          col;
      k_item_in = f_item_ff;
      col       = f_item_ff.colour;
      for (int a = 0; a < 4; a++) begin
         fac   = cfg.color_factors[16*a +: 16];
         fac34 = {{14{fac[15]}}, fac, 4'b0000};
         col34 = {{2{col[31]}}, col};
         if (f_chg_ff[a]) begin
            col = sat_s34(col34 + fac34);
         end
      end
      k_item_in.colour = col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else begin
         if (f_en) begin
            f_valid_ff <= f_valid_in;
         end
         if (k_en) begin
            k_valid_ff <= k_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_en) begin
         f_item_ff <= f_item_in;
         f_chg_ff  <= f_chg_in;
      end
      if (k_en) begin
         k_item_ff <= k_item_in;
      end
   end

   assign out_valid = k_valid_ff;
   assign out_item  = k_item_ff;

   // an item with no folded axis keeps its colour
   assert property (@(posedge clock) disable iff (reset)
      f_valid_ff && k_en && (f_chg_ff == 4'b0000) |=> k_item_ff.colour == $past(f_item_ff.colour))
      else $error("colour changed without a folded axis");

endmodule

// ===== design/bf4s_scale.sv =====
// one scale stage: products registered, then rounding and saturation registered
module bf4s_scale import bf4s_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  item_type  in_item,
   output logic      out_valid,
   input  logic      out_ready,
   output item_type  out_item
);

   typedef logic signed [55:0] prod_type;

   logic signed [23:0] sc;
   logic [23:0]        mag;
   logic [15:0]        start;
   logic [15:0]        stop;

   logic     m_valid_ff;
   logic     m_valid_in;
   item_type m_item_ff;
   logic     m_apply_ff;
   logic     m_apply_in;
   prod_type m_prod_ff [4];
   prod_type m_prod_in [4];
   logic [47:0] m_ph_ff;
   logic [47:0] m_ph_in;
   logic [47:0] m_pl_ff;
   logic [47:0] m_pl_in;
   logic     m_en;

   logic     r_valid_ff;
   logic     r_valid_in;
   item_type r_item_ff;
   item_type r_item_in;
   logic     r_en;

   assign sc    = stage_cfg[23:0];
   assign start = stage_cfg[39:24];
   assign stop  = stage_cfg[55:40];
   assign mag   = sc[23] ? 24'(-sc) : 24'(sc);

   assign r_en       = !r_valid_ff || out_ready;
   assign m_en       = !m_valid_ff || r_en;
   assign in_ready   = m_en;
   assign m_valid_in = in_valid;
   assign r_valid_in = m_valid_ff;

   always_comb begin
      m_apply_in = (in_item.iteration >= start) && (in_item.iteration < stop);
      for (int a = 0; a < 4; a++) begin
         m_prod_in[a] = $signed(in_item.c[a]) * sc;
      end
      m_ph_in = in_item.deriv[47:24] * mag;
      m_pl_in = in_item.deriv[23:0] * mag;
   end

   // inside the iteration window round to nearest, ties upward, then saturate
   always_comb begin
      prod_type    rnd;
      logic [48:0] plr;
      logic [56:0] dsum;
      r_item_in = m_item_ff;
      rnd       = '0;
      plr       = {1'b0, m_pl_ff} + 49'd32768;
      dsum      = 57'({m_ph_ff, 8'h00}) + 57'(plr[48:16]);
      if (m_apply_ff) begin
         for (int a = 0; a < 4; a++) begin
            rnd            = m_prod_ff[a] + 56'sd32768;
            r_item_in.c[a] = sat_s40(rnd[55:16]);
         end
         r_item_in.deriv = (dsum[56:48] != 9'd0) ? DERIV_MAX : dsum[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (m_en) begin
            m_valid_ff <= m_valid_in;
         end
         if (r_en) begin
            r_valid_ff <= r_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_en) begin
         m_item_ff  <= in_item;
         m_apply_ff <= m_apply_in;
         m_prod_ff  <= m_prod_in;
         m_ph_ff    <= m_ph_in;
         m_pl_ff    <= m_pl_in;
      end
      if (r_en) begin
         r_item_ff <= r_item_in;
      end
   end

   assign out_valid = r_valid_ff;
   assign out_item  = r_item_ff;

   // outside the iteration window the point and derivative pass untouched
   assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && r_en && !m_apply_ff |=>
         (r_item_ff.c == $past(m_item_ff.c)) && (r_item_ff.deriv == $past(m_item_ff.deriv)))
      else $error("inactive scale stage altered the request");

   assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && r_en |=> r_item_ff.iteration == $past(m_item_ff.iteration))
      else $error("iteration index corrupted in scale stage");

endmodule
